// File: rtl/assert_macros.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ttb_pkg.sv
package ttb_pkg;

    localparam int POS_W            = 32;
    localparam int UV_W             = 16;
    localparam int UV_FRAC_BITS_DEF = 12;
    localparam int DP_W             = POS_W + 1;
    localparam int DUV_W            = UV_W + 1;
    localparam int PROD_W           = DP_W + DUV_W;
    localparam int NUM_W            = PROD_W + 1;
    localparam int DET_W            = 2 * DUV_W + 1;
    localparam int QUOT_W           = POS_W + 1;
    localparam int REM_W            = DET_W + 1;

    localparam logic [5:0] DIV_LAST  = 6'd32;
    localparam logic [2:0] COMP_LAST = 3'd5;
    localparam logic [2:0] COMP_BIT  = 3'd3;
    localparam logic [1:0] EMIT_LAST = 2'd2;

    localparam logic [1:0] PHASE_V0 = 2'd0;
    localparam logic [1:0] PHASE_V1 = 2'd1;
    localparam logic [1:0] PHASE_V2 = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [UV_W-1:0]  tex_u;
        logic signed [UV_W-1:0]  tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [POS_W-1:0] tangent_x;
        logic signed [POS_W-1:0] tangent_y;
        logic signed [POS_W-1:0] tangent_z;
        logic signed [POS_W-1:0] bitangent_x;
        logic signed [POS_W-1:0] bitangent_y;
        logic signed [POS_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    last_of_run;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_MUL,
        ST_DET_SUB,
        ST_NUM_MUL,
        ST_NUM_SUB,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_v0;
        logic       load_v1;
        logic       load_v2;
        logic       det_mul;
        logic       det_sub;
        logic       num_mul;
        logic       num_sub;
        logic       prep;
        logic       load_div;
        logic       div_step;
        logic       fin;
        logic       last;
        logic [2:0] comp;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
    } status_t;

endpackage

// File: rtl/triangle_tangent_basis_unit.sv
// Channel   Word      Handshake                  Direction
// vertex    vertex_t  vertex_valid/vertex_stall  in
// result    result_t  result_valid/result_stall  out
//
// Vertices 0 and 1 of a triangle are stored as they are taken.
// Vertex 2 starts the solve, paced by one shared pair of 33x17 multipliers
// and a one-bit-per-cycle restoring divider (33 quotient bits per component).
// A zero determinant skips the divider. Then three words are offered.
// vertex_stall is high from the third vertex until the third result word is taken.
// rst_n is asynchronous; reset returns to vertex 0 of a new triangle.
module triangle_tangent_basis_unit #(
    parameter int UV_FRAC_BITS = ttb_pkg::UV_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  ttb_pkg::vertex_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output ttb_pkg::result_t  result
);
    import ttb_pkg::*;

    cmd_t    cmd;
    status_t status;

    ttb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    ttb_datapath #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .vertex (vertex),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

// File: rtl/ttb_ctrl.sv
`include "assert_macros.svh"

module ttb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  ttb_pkg::status_t  status,
    output ttb_pkg::cmd_t     cmd
);
    import ttb_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [2:0] comp_reg, comp_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic [1:0] emit_reg, emit_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PHASE_V0;
            comp_reg    <= '0;
            div_cnt_reg <= '0;
            emit_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            comp_reg    <= comp_next;
            div_cnt_reg <= div_cnt_next;
            emit_reg    <= emit_next;
        end
    end

    assign vertex_stall = (state_reg != ST_IDLE);
    assign result_valid = (state_reg == ST_EMIT);
    assign accept       = vertex_valid && !vertex_stall;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        comp_next    = comp_reg;
        div_cnt_next = div_cnt_reg;
        emit_next    = emit_reg;
        cmd          = '0;
        cmd.comp     = comp_reg;
        cmd.last     = (emit_reg == EMIT_LAST);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (phase_reg == PHASE_V0)
                    begin
                        cmd.load_v0 = 1'b1;
                        phase_next  = PHASE_V1;
                    end
                    else if (phase_reg == PHASE_V1)
                    begin
                        cmd.load_v1 = 1'b1;
                        phase_next  = PHASE_V2;
                    end
                    else
                    begin
                        cmd.load_v2 = 1'b1;
                        phase_next  = PHASE_V0;
                        state_next  = ST_DET_MUL;
                    end
                end
            end
            ST_DET_MUL:
            begin
                cmd.det_mul = 1'b1;
                state_next  = ST_DET_SUB;
            end
            ST_DET_SUB:
            begin
                cmd.det_sub = 1'b1;
                comp_next   = '0;
                emit_next   = '0;
                state_next  = status.det_zero ? ST_EMIT : ST_NUM_MUL;
            end
            ST_NUM_MUL:
            begin
                cmd.num_mul = 1'b1;
                state_next  = ST_NUM_SUB;
            end
            ST_NUM_SUB:
            begin
                cmd.num_sub = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_div = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = ST_FIN;
                else
                    div_cnt_next = div_cnt_reg + 6'd1;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (comp_reg == COMP_LAST)
                    state_next = ST_EMIT;
                else
                begin
                    comp_next  = comp_reg + 3'd1;
                    state_next = ST_NUM_MUL;
                end
            end
            ST_EMIT:
            begin
                if (!result_stall)
                begin
                    if (emit_reg == EMIT_LAST)
                    begin
                        emit_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        emit_next = emit_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TTB_ASSERT(a_phase_range, phase_reg != 2'd3, "vertex phase out of range")
    `TTB_ASSERT(a_div_range, state_reg != ST_DIV || div_cnt_reg <= DIV_LAST,
        "divider ran past its last step")
    `TTB_ASSERT_NEXT(a_third_word_ends, result_valid && !result_stall && cmd.last,
        state_reg == ST_IDLE && phase_reg == PHASE_V0, "run did not end after third word")
    `TTB_ASSERT_NEXT(a_third_vertex_starts, accept && phase_reg == PHASE_V2,
        state_reg == ST_DET_MUL, "third vertex did not start the solve")

endmodule

// File: rtl/ttb_datapath.sv
module ttb_datapath #(
    parameter int UV_FRAC_BITS = ttb_pkg::UV_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  ttb_pkg::vertex_t  vertex,
    input  ttb_pkg::cmd_t     cmd,
    output ttb_pkg::status_t  status,
    output ttb_pkg::result_t  result
);
    import ttb_pkg::*;

    localparam int NW   = NUM_W + UV_FRAC_BITS + 1;
    localparam int HI_W = NW - QUOT_W;

    logic signed [POS_W-1:0]  p0_reg [3];
    logic signed [POS_W-1:0]  p1_reg [3];
    logic signed [UV_W-1:0]   u0_reg, v0_reg, u1_reg, v1_reg;
    logic signed [DP_W-1:0]   dp1_reg [3];
    logic signed [DP_W-1:0]   dp2_reg [3];
    logic signed [DUV_W-1:0]  d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [DET_W-1:0]         det_mag_reg;
    logic                     det_neg_reg, degen_reg;
    logic [NW-1:0]            n_reg;
    logic                     neg_reg, ovf_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [QUOT_W-1:0]        sh_reg;
    logic [POS_W-1:0]         res_reg [6];

    logic [POS_W-1:0]         px [3];
    logic                     bit_side;
    logic [1:0]               j;
    logic signed [DP_W-1:0]   ma1, mb1;
    logic signed [DUV_W-1:0]  ma2, mb2;
    logic signed [PROD_W-1:0] prod_a_next, prod_b_next, diff, diff_abs;
    logic signed [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]         num_mag;
    logic [HI_W-1:0]          hi;
    logic [REM_W-1:0]         hi_ext, d_ext, trial;
    logic                     ge;
    logic [QUOT_W-1:0]        neg_q;
    logic [POS_W-1:0]         sat_val;

    assign px[0] = vertex.pos_x;
    assign px[1] = vertex.pos_y;
    assign px[2] = vertex.pos_z;

    // components 0..2 are tangent, 3..5 bitangent
    assign bit_side = cmd.comp >= COMP_BIT;
    assign j        = bit_side ? 2'(cmd.comp - COMP_BIT) : cmd.comp[1:0];

    always_comb
    begin
        if (cmd.det_mul)
        begin
            ma1 = DP_W'(d1u_reg);
            ma2 = d2v_reg;
            mb1 = DP_W'(d1v_reg);
            mb2 = d2u_reg;
        end
        else if (bit_side)
        begin
            ma1 = dp2_reg[j];
            ma2 = d1u_reg;
            mb1 = dp1_reg[j];
            mb2 = d2u_reg;
        end
        else
        begin
            ma1 = dp1_reg[j];
            ma2 = d2v_reg;
            mb1 = dp2_reg[j];
            mb2 = d1v_reg;
        end
    end

    assign prod_a_next = ma1 * ma2;
    assign prod_b_next = mb1 * mb2;
    assign diff        = prod_a_reg - prod_b_reg;
    assign diff_abs    = diff[PROD_W-1] ? -diff : diff;
    assign num_next    = NUM_W'(prod_a_reg) - NUM_W'(prod_b_reg);
    assign num_mag     = num_reg[NUM_W-1] ? -num_reg : num_reg;
    assign hi          = n_reg[NW-1:QUOT_W];
    assign hi_ext      = REM_W'(hi);
    assign d_ext       = REM_W'(det_mag_reg);
    assign trial       = {rem_reg[REM_W-2:0], sh_reg[QUOT_W-1]};
    assign ge          = trial >= d_ext;
    assign neg_q       = ~sh_reg + QUOT_W'(1);

    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || sh_reg > QUOT_W'(33'h0_8000_0000))
                sat_val = 32'h8000_0000;
            else
                sat_val = neg_q[POS_W-1:0];
        end
        else
        begin
            if (ovf_reg || sh_reg > QUOT_W'(33'h0_7FFF_FFFF))
                sat_val = 32'h7FFF_FFFF;
            else
                sat_val = sh_reg[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_v0)
        begin
            for (int i = 0; i < 3; i++)
                p0_reg[i] <= px[i];
            u0_reg <= vertex.tex_u;
            v0_reg <= vertex.tex_v;
        end
        if (cmd.load_v1)
        begin
            for (int i = 0; i < 3; i++)
                p1_reg[i] <= px[i];
            u1_reg <= vertex.tex_u;
            v1_reg <= vertex.tex_v;
        end
        if (cmd.load_v2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp1_reg[i] <= DP_W'(p1_reg[i]) - DP_W'(p0_reg[i]);
                dp2_reg[i] <= DP_W'($signed(px[i])) - DP_W'(p0_reg[i]);
            end
            d1u_reg <= DUV_W'(u1_reg) - DUV_W'(u0_reg);
            d1v_reg <= DUV_W'(v1_reg) - DUV_W'(v0_reg);
            d2u_reg <= DUV_W'(vertex.tex_u) - DUV_W'(u0_reg);
            d2v_reg <= DUV_W'(vertex.tex_v) - DUV_W'(v0_reg);
        end
        if (cmd.det_mul || cmd.num_mul)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (cmd.det_sub)
        begin
            det_mag_reg <= diff_abs[DET_W-1:0];
            det_neg_reg <= diff[PROD_W-1];
            degen_reg   <= status.det_zero;
        end
        if (cmd.num_sub)
            num_reg <= num_next;
        if (cmd.prep)
        begin
            // round half away from zero: add half the divisor to the magnitude
            n_reg   <= (NW'(num_mag) << UV_FRAC_BITS) + NW'(det_mag_reg >> 1);
            neg_reg <= num_reg[NUM_W-1] ^ det_neg_reg;
        end
        if (cmd.load_div)
        begin
            rem_reg <= hi_ext;
            ovf_reg <= hi_ext >= d_ext;
            sh_reg  <= n_reg[QUOT_W-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? trial - d_ext : trial;
            sh_reg  <= {sh_reg[QUOT_W-2:0], ge};
        end
        if (cmd.fin)
            res_reg[cmd.comp] <= sat_val;
    end

    assign status.det_zero = (prod_a_reg == prod_b_reg);

    always_comb
    begin
        result.tangent_x   = degen_reg ? '0 : res_reg[0];
        result.tangent_y   = degen_reg ? '0 : res_reg[1];
        result.tangent_z   = degen_reg ? '0 : res_reg[2];
        result.bitangent_x = degen_reg ? '0 : res_reg[3];
        result.bitangent_y = degen_reg ? '0 : res_reg[4];
        result.bitangent_z = degen_reg ? '0 : res_reg[5];
        result.degenerate  = degen_reg;
        result.last_of_run = cmd.last;
    end

endmodule

// File: tb/tb_triangle_tangent_basis_unit.sv
module tb_triangle_tangent_basis_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ttb_pkg::*;

    localparam int UVF = 12;

    // Predicts the three tangent-basis words per triangle and checks them in order.
    class tangent_board;
        logic signed [31:0] held_p [6];
        logic signed [15:0] held_uv [4];
        int phase;
        result_t pending [$];
        int errors;
        int triangles;
        int degenerates;
        int saturations;

        function new();
            foreach (held_p[i]) held_p[i] = '0;
            foreach (held_uv[i]) held_uv[i] = '0;
            phase = 0;
            errors = 0;
            triangles = 0;
            degenerates = 0;
            saturations = 0;
        endfunction

        function logic signed [31:0] div_round_sat(longint num, longint den);
            bit neg;
            longint unsigned n;
            longint unsigned d;
            longint unsigned q;
            neg = (num < 0) != (den < 0);
            d = (den < 0) ? -den : den;
            n = ((num < 0) ? -num : num);
            n = (n << UVF) + (d >> 1);
            q = n / d;
            if (neg) begin
                if (q > 64'd2147483648) begin
                    saturations++;
                    return 32'sh80000000;
                end
                return 32'(-longint'(q));
            end
            if (q > 64'd2147483647) begin
                saturations++;
                return 32'sh7fffffff;
            end
            return q[31:0];
        endfunction

        function void note_vertex(vertex_t w);
            longint p [3];
            longint dp1, dp2, d1u, d1v, d2u, d2v, det;
            logic signed [31:0] tv [3];
            logic signed [31:0] bv [3];
            result_t r;
            p[0] = w.pos_x;
            p[1] = w.pos_y;
            p[2] = w.pos_z;
            if (phase < 2) begin
                for (int i = 0; i < 3; i++) held_p[phase*3+i] = 32'(p[i]);
                held_uv[phase*2] = w.tex_u;
                held_uv[phase*2+1] = w.tex_v;
                phase++;
                return;
            end
            phase = 0;
            triangles++;
            d1u = longint'(held_uv[2]) - held_uv[0];
            d1v = longint'(held_uv[3]) - held_uv[1];
            d2u = longint'(w.tex_u) - held_uv[0];
            d2v = longint'(w.tex_v) - held_uv[1];
            det = d1u * d2v - d1v * d2u;
            if (det == 0) degenerates++;
            for (int i = 0; i < 3; i++) begin
                dp1 = longint'(held_p[3+i]) - held_p[i];
                dp2 = p[i] - held_p[i];
                if (det == 0) begin
                    tv[i] = '0;
                    bv[i] = '0;
                end else begin
                    tv[i] = div_round_sat(dp1 * d2v - dp2 * d1v, det);
                    bv[i] = div_round_sat(dp2 * d1u - dp1 * d2u, det);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r.tangent_x = tv[0];
                r.tangent_y = tv[1];
                r.tangent_z = tv[2];
                r.bitangent_x = bv[0];
                r.bitangent_y = bv[1];
                r.bitangent_z = bv[2];
                r.degenerate = (det == 0);
                r.last_of_run = (k == 2);
                pending.insert(pending.size(), r);
            end
        endfunction

        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tangent_x !== e.tangent_x)
                report("tangent_x", e.tangent_x, got.tangent_x);
            if (got.tangent_y !== e.tangent_y)
                report("tangent_y", e.tangent_y, got.tangent_y);
            if (got.tangent_z !== e.tangent_z)
                report("tangent_z", e.tangent_z, got.tangent_z);
            if (got.bitangent_x !== e.bitangent_x)
                report("bitangent_x", e.bitangent_x, got.bitangent_x);
            if (got.bitangent_y !== e.bitangent_y)
                report("bitangent_y", e.bitangent_y, got.bitangent_y);
            if (got.bitangent_z !== e.bitangent_z)
                report("bitangent_z", e.bitangent_z, got.bitangent_z);
            if (got.degenerate !== e.degenerate)
                report("degenerate", e.degenerate, got.degenerate);
            if (got.last_of_run !== e.last_of_run)
                report("last_of_run", e.last_of_run, got.last_of_run);
        endfunction

        function void report(string field, longint e, longint a);
            $display("%0t: %s expected %0d got %0d", $time, field, e, a);
            errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic vertex_valid = 0;
    logic vertex_stall;
    vertex_t vertex = '0;
    logic result_valid;
    logic result_stall = 0;
    result_t result;

    tangent_board board = new();
    longint cycle = 0;
    bit hold_off = 0;
    bit out_noise = 1;
    int words_taken = 0;

    triangle_tangent_basis_unit uut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 1500000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && vertex_valid && !vertex_stall) board.note_vertex(vertex);
        if (rst_n && result_valid && !result_stall) begin
            board.check_result(result);
            words_taken++;
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 300);
    endfunction

    // Receiver: random stalls, with quiet stretches and a forced long hold-off.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) result_stall <= 1;
            else if (out_noise && $urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0)
                begin
                    result_stall <= 1;
                    repeat (g) @(negedge clk);
                end
                result_stall <= 0;
            end else result_stall <= 0;
        end
    end

    // valid stays up after a word is taken; the next word, a gap or drain() replaces it
    task automatic send_word(vertex_t w, bit use_gap);
        int g;
        if (use_gap && $urandom_range(0, 2) == 0) begin
            g = gap_len();
            if (g > 0)
            begin
                vertex_valid <= 0;
                repeat (g) @(negedge clk);
            end
        end
        vertex <= w;
        vertex_valid <= 1;
        @(posedge clk);
        while (vertex_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic vertex_t rand_vertex(int kind);
        vertex_t w;
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        w.tex_u = 16'($urandom);
        w.tex_v = 16'($urandom);
        if (kind == 1) begin
            // small, well-conditioned geometry
            w.pos_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            w.pos_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            w.pos_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            w.tex_u = 16'($signed($urandom_range(0, 8192)) - 4096);
            w.tex_v = 16'($signed($urandom_range(0, 8192)) - 4096);
        end
        return w;
    endfunction

    task automatic send_tri(vertex_t a, vertex_t b, vertex_t c, bit use_gap);
        send_word(a, use_gap);
        send_word(b, use_gap);
        send_word(c, use_gap);
    endtask

    task automatic drain();
        vertex_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        vertex_t a, b, c;
        int kind;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // unit right triangle in UV
        a = '0;
        b = '{32'sh10000, 0, 0, 16'sh1000, 0};
        c = '{0, 32'sh10000, 0, 0, 16'sh1000};
        send_tri(a, b, c, 0);
        // zero determinant: identical UVs
        send_tri('{1, 2, 3, 5, 5}, '{4, 5, 6, 5, 5}, '{7, 8, 9, 5, 5}, 0);
        // extreme positions, tiny UV det: saturates both ways
        a = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh8000};
        b = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sh8001, 16'sh8000};
        c = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'sh8000, 16'sh8001};
        send_tri(a, b, c, 0);
        // extreme UVs, determinant 65535 squared
        a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff};
        b = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh7fff};
        c = '{32'sh12345678, 32'shedcba987, 0, 16'sh7fff, 16'sh8000};
        send_tri(a, b, c, 0);
        // rounding by a det of magnitude 3 in UV lsbs, both signs
        send_tri('{0, 0, 0, 0, 0}, '{1, 0, 0, 3, 0}, '{0, 1, 0, 0, 1}, 0);
        send_tri('{0, 0, 0, 0, 0}, '{-1, 5, 0, -3, 0}, '{0, -1, 7, 0, 1}, 0);
        drain();

        // long receiver hold-off while the sender keeps pushing
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_word(rand_vertex(1), 0);
        join
        drain();

        for (int i = 0; i < 135; i++) begin
            kind = $urandom_range(0, 9);
            out_noise = (i % 40) < 30;
            if (kind < 6) send_tri(rand_vertex(1), rand_vertex(1), rand_vertex(1), 1);
            else if (kind < 8) send_tri(rand_vertex(0), rand_vertex(0), rand_vertex(0), 1);
            else begin
                a = rand_vertex(1);
                b = rand_vertex(1);
                c = rand_vertex(1);
                // collinear UVs force a degenerate triangle
                b.tex_u = a.tex_u;
                c.tex_u = a.tex_u;
                send_tri(a, b, c, 1);
            end
            if (i == 70) drain();
        end

        drain();
        repeat (300) @(negedge clk);
        $display("%0d triangles, %0d degenerate, %0d saturated components, %0d words checked",
                 board.triangles, board.degenerates, board.saturations, words_taken);
        if (board.errors == 0 && board.pending.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// File: triangle_tangent_basis_unit.f
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_ctrl.sv
rtl/ttb_datapath.sv
rtl/triangle_tangent_basis_unit.sv
tb/tb_triangle_tangent_basis_unit.sv
